// File: sv/scalar_kalman_filter_core_macros.svh
// Assertion macros shared by the Kalman filter RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef SCALAR_KALMAN_FILTER_CORE_MACROS_SVH
`define SCALAR_KALMAN_FILTER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SKF_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SKF_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/skf_pkg.sv
// Package for the scalar Kalman filter: fixed-point constants, sequencer states and
// the divider status struct. No dependencies.
`default_nettype none

package skf_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int MEAS_WIDTH = 16;

  localparam int DATA_W    = 32;
  localparam int GAIN_W    = 17;
  localparam int GAIN_SHIFT = 16;
  localparam int PROD_W    = GAIN_W + DATA_W;
  localparam int DEN_W     = DATA_W + 1;
  localparam int REM_W     = DATA_W + 2;
  localparam int DIV_STEPS = GAIN_SHIFT;
  localparam int DCNT_W    = $clog2(DIV_STEPS + 1);

  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_SHIFT;
  localparam logic [DATA_W-1:0] COV_ONE  = DATA_W'(1) << FRAC_BITS;
  localparam logic [63:0]       MEAS_MASK = (64'd1 << MEAS_WIDTH) - 64'd1;

  localparam logic [DATA_W-1:0] INIT_EST_RST = '0;
  localparam logic [DATA_W-1:0] PROC_NOISE_RST = DATA_W'(655);
  localparam logic [DATA_W-1:0] MEAS_NOISE_RST = DATA_W'(6554);

  typedef enum logic [1:0] {
    CFG_INIT_EST   = 2'd0,
    CFG_PROC_NOISE = 2'd1,
    CFG_MEAS_NOISE = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREDICT,
    ST_GAIN,
    ST_DIV_WAIT,
    ST_MUL_EST,
    ST_MUL_COV,
    ST_COV_WB,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

`default_nettype wire

// File: sv/scalar_kalman_filter_core.sv
// Top level of the scalar Kalman filter: sequencer, state and configuration registers.
// Depends on skf_pkg, skf_div, skf_mul and scalar_kalman_filter_core_macros.svh.
//
//   Channel  Direction  Handshake             Payload
//   in       input      in_valid / in_ready   command, measurement
//   out      output     out_valid / out_ready estimate, gain, covariance
//   cfg      input      cfg_write             cfg_index, cfg_data
//
// An update steps through predict, gain, divider wait, the two multiply states and
// covariance write-back before the final state registers its result; a reinit goes
// straight to the final state. A new request is taken only once the sequencer is back in idle.
// Reset is synchronous: estimate 0, covariance 1.0, noise registers at their defaults.
// A held result does not block acceptance of the next request; a finished result only
// waits in the final state while the output register is still occupied.
`default_nettype none

`include "scalar_kalman_filter_core_macros.svh"

module scalar_kalman_filter_core (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_write,
  input  wire logic [1:0]                   cfg_index,
  input  wire logic [skf_pkg::DATA_W-1:0]   cfg_data,
  input  wire logic                         in_valid,
  output      logic                         in_ready,
  input  wire logic                         command,
  input  wire logic [15:0]                  measurement,
  output      logic                         out_valid,
  input  wire logic                         out_ready,
  output      logic [skf_pkg::DATA_W-1:0]   estimate,
  output      logic [skf_pkg::GAIN_W-1:0]   gain,
  output      logic [skf_pkg::DATA_W-1:0]   covariance
);
  import skf_pkg::*;

  state_t            state;
  state_t            state_next;

  logic [DATA_W-1:0] init_est;
  logic [DATA_W-1:0] proc_noise;
  logic [DATA_W-1:0] meas_noise;

  logic [DATA_W-1:0] estimate_reg;
  logic [DATA_W-1:0] covariance_reg;
  logic [GAIN_W-1:0] gain_reg;
  logic [DATA_W-1:0] pm_reg;
  logic [15:0]       meas_reg;
  logic              up_reg;

  logic              accept;
  logic              out_free;
  logic              div_start;
  logic              mul_en;
  logic [GAIN_W-1:0] mul_a;
  logic [DATA_W-1:0] mul_b;
  logic [PROD_W-1:0] prod;
  logic [GAIN_W-1:0] div_q;
  div_status_t       div_st;

  logic [DEN_W-1:0]  pm_sum;
  logic [DATA_W-1:0] pm_sat;
  logic [DEN_W-1:0]  den;
  logic [63:0]       m_full;
  logic [DATA_W-1:0] m_val;
  logic              m_ge;
  logic [DATA_W-1:0] diff;
  logic [DEN_W-1:0]  step_up;
  logic [DEN_W-1:0]  step_dn;
  logic [DATA_W-1:0] cov_new;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      init_est   <= INIT_EST_RST;
      proc_noise <= PROC_NOISE_RST;
      meas_noise <= MEAS_NOISE_RST;
    end else if (cfg_write) begin
      case (cfg_idx_t'(cfg_index))
        CFG_INIT_EST:   init_est   <= cfg_data;
        CFG_PROC_NOISE: proc_noise <= cfg_data;
        CFG_MEAS_NOISE: meas_noise <= cfg_data;
        default:        ;
      endcase
    end
  end

  // Datapath arithmetic around the shared units.
  assign pm_sum = DEN_W'(covariance_reg) + DEN_W'(proc_noise);
  assign pm_sat = pm_sum[DATA_W] ? '1 : pm_sum[DATA_W-1:0];
  assign den    = DEN_W'(pm_reg) + DEN_W'(meas_noise);

  assign m_full = ((64'(meas_reg)) & MEAS_MASK) << FRAC_BITS;
  assign m_val  = (m_full[63:DATA_W] != '0) ? '1 : m_full[DATA_W-1:0];
  assign m_ge   = (m_val >= estimate_reg);
  assign diff   = m_ge ? m_val - estimate_reg : estimate_reg - m_val;

  // Moving up rounds the step down; moving down rounds it up, so both floor.
  assign step_up = DEN_W'(prod >> GAIN_SHIFT);
  assign step_dn = DEN_W'(((PROD_W + 1)'(prod) + (PROD_W + 1)'(GAIN_ONE - 1'b1))
                          >> GAIN_SHIFT);
  assign cov_new = DATA_W'(prod >> GAIN_SHIFT);

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    div_start  = 1'b0;
    mul_en     = 1'b0;
    mul_a      = gain_reg;
    mul_b      = diff;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = command ? ST_DONE : ST_PREDICT;
        end
      end
      ST_PREDICT: begin
        state_next = ST_GAIN;
      end
      ST_GAIN: begin
        div_start  = 1'b1;
        state_next = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_st.done) begin
          state_next = ST_MUL_EST;
        end
      end
      ST_MUL_EST: begin
        mul_en     = 1'b1;
        state_next = ST_MUL_COV;
      end
      ST_MUL_COV: begin
        mul_en     = 1'b1;
        mul_a      = GAIN_ONE - gain_reg;
        mul_b      = pm_reg;
        state_next = ST_COV_WB;
      end
      ST_COV_WB: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Filter state.
  always_ff @(posedge clk) begin
    if (rst) begin
      estimate_reg   <= '0;
      covariance_reg <= COV_ONE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept && command) begin
            estimate_reg   <= init_est;
            covariance_reg <= COV_ONE;
          end
        end
        ST_MUL_COV: begin
          estimate_reg <= up_reg ? estimate_reg + step_up[DATA_W-1:0]
                                 : estimate_reg - step_dn[DATA_W-1:0];
        end
        ST_COV_WB: begin
          covariance_reg <= cov_new;
        end
        default: ;
      endcase
    end
  end

  // Working registers for one update.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          meas_reg <= measurement;
          gain_reg <= '0;
        end
      end
      ST_PREDICT: pm_reg <= pm_sat;
      ST_DIV_WAIT: begin
        if (div_st.done) begin
          gain_reg <= div_q;
        end
      end
      ST_MUL_EST: up_reg <= m_ge;
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      estimate   <= estimate_reg;
      gain       <= gain_reg;
      covariance <= covariance_reg;
    end
  end

  skf_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num    (pm_reg),
    .den    (den),
    .quot   (div_q),
    .status (div_st)
  );

  skf_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  `SKF_ASSERT_IMP(a_gain_le_one, clk, rst, out_valid, gain <= GAIN_ONE, "gain above one")
  `SKF_ASSERT_IMP(a_div_owner, clk, rst, div_st.busy || div_st.done,
                  state == ST_DIV_WAIT, "divider active outside its wait state")
  `SKF_ASSERT_NXT(a_one_in_flight, clk, rst, accept, !in_ready,
                  "request accepted while another is in flight")
  `SKF_ASSERT_IMP(a_cov_shrinks, clk, rst, state == ST_COV_WB, cov_new <= pm_reg,
                  "updated covariance exceeds predicted covariance")

endmodule

`default_nettype wire

// File: sv/skf_div.sv
// Serial restoring divider for the Kalman gain, one quotient bit per cycle.
// Depends on skf_pkg.
`default_nettype none

module skf_div (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [skf_pkg::DATA_W-1:0]   num,
  input  wire logic [skf_pkg::DEN_W-1:0]    den,
  output      logic [skf_pkg::GAIN_W-1:0]   quot,
  output      skf_pkg::div_status_t         status
);
  import skf_pkg::*;

  logic [REM_W-1:0]  rem;
  logic [REM_W-1:0]  den_ext;
  logic [REM_W-1:0]  load_cand;
  logic [REM_W-1:0]  step_cand;
  logic [DCNT_W-1:0] cnt;
  logic              done;
  logic              den_zero;
  logic              load_ge;
  logic              step_ge;

  assign den_ext   = REM_W'(den);
  assign den_zero  = (den == '0);
  // The numerator never exceeds the divisor, so the top quotient bit is settled by
  // one compare at load time and the remaining bits take one shift step each.
  assign load_cand = REM_W'(num);
  assign load_ge   = (load_cand >= den_ext);
  assign step_cand = {rem[REM_W-2:0], 1'b0};
  assign step_ge   = (step_cand >= den_ext);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      cnt  <= den_zero ? '0 : DCNT_W'(DIV_STEPS);
      done <= den_zero;
    end else if (cnt != '0) begin
      cnt  <= cnt - 1'b1;
      done <= (cnt == DCNT_W'(1));
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      if (den_zero) begin
        quot <= GAIN_ONE;
        rem  <= '0;
      end else begin
        quot <= GAIN_W'(load_ge);
        rem  <= load_ge ? load_cand - den_ext : load_cand;
      end
    end else if (cnt != '0) begin
      quot <= {quot[GAIN_W-2:0], step_ge};
      rem  <= step_ge ? step_cand - den_ext : step_cand;
    end
  end

  assign status.busy = (cnt != '0);
  assign status.done = done;

endmodule

`default_nettype wire

// File: sv/skf_mul.sv
// Shared registered multiplier: gain-sized operand times a data word.
// Depends on skf_pkg.
`default_nettype none

module skf_mul (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic [skf_pkg::GAIN_W-1:0]  a,
  input  wire logic [skf_pkg::DATA_W-1:0]  b,
  output      logic [skf_pkg::PROD_W-1:0]  prod
);
  import skf_pkg::*;

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= PROD_W'(a) * PROD_W'(b);
    end
  end

endmodule

`default_nettype wire
